/* design/phl_pkg.sv */
`timescale 1ns / 1ps
package phl_pkg;

    localparam int unsigned BUCKETS = 256;
    localparam int unsigned SLOTS   = 1024;
    localparam int BKT_AW  = $clog2(BUCKETS);
    localparam int SLOT_AW = $clog2(SLOTS);

    localparam logic [20:0] PRIME = 21'd1984533;
    // floor(2^42 / PRIME) for the quotient estimate
    localparam logic [21:0] RECIP = 22'((64'd1 << 42) / 64'(PRIME));
    // key + 2^31 offset, folded back: key = ukey_flipped + KEY_OFS (mod PRIME)
    localparam logic [20:0] KEY_OFS =
        21'((64'(PRIME) - ((64'd1 << 31) % 64'(PRIME))) % 64'(PRIME));

    localparam logic [1:0] FUNC_DESC  = 2'd0;
    localparam logic [1:0] FUNC_SLOT  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic [1:0] CFG_FIRST_MULT  = 2'd0;
    localparam logic [1:0] CFG_FIRST_ADD   = 2'd1;
    localparam logic [1:0] CFG_NUM_BUCKETS = 2'd2;

    typedef struct packed {
        logic [20:0] mult;
        logic [20:0] add;
        logic [10:0] count;
        logic [9:0]  base;
    } t_bucket;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
    } t_slot;

    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  idx;
        logic [31:0] key;
        logic [20:0] bmult;
        logic [20:0] badd;
        logic [10:0] count;
        logic [9:0]  base;
        logic        svalid;
    } t_item;

    typedef struct packed {
        t_item       item;
        logic [20:0] kr;
    } t_l1_sb;

    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  idx;
        logic [31:0] key;
        logic        svalid;
        logic [9:0]  base;
        logic        ok;
    } t_l2_sb;

    // Underestimates floor(x / PRIME) by at most 3.
    function automatic logic [22:0] f_quot_est(input logic [42:0] x);
        logic [44:0] p;
        p = 45'(x[42:20]) * 45'(RECIP);
        return p[44:22];
    endfunction

    // Remainder below 4*PRIME, so 24 low bits suffice.
    function automatic logic [23:0] f_rem_est(input logic [42:0] x, input logic [22:0] q);
        logic [43:0] qp;
        qp = 44'(q) * 44'(PRIME);
        return x[23:0] - qp[23:0];
    endfunction

    function automatic logic [20:0] f_rem_fix(input logic [23:0] r);
        logic [23:0] t;
        t = r;
        if (t >= {2'b00, PRIME, 1'b0}) begin
            t = t - {2'b00, PRIME, 1'b0};
        end
        if (t >= {3'b000, PRIME}) begin
            t = t - {3'b000, PRIME};
        end
        return t[20:0];
    endfunction

endpackage

/* design/phl_hash.sv */
`timescale 1ns / 1ps
module phl_hash #(
    parameter int SbWidth = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [20:0]        i_mult,
    input  logic [20:0]        i_add,
    input  logic [10:0]        i_modulus,
    input  logic [20:0]        i_kr,
    input  logic [SbWidth-1:0] i_sb,
    output logic               o_valid,
    output logic [10:0]        o_rem,
    output logic [SbWidth-1:0] o_sb
);
    import phl_pkg::*;

    localparam int DivSteps = 21;

    function automatic logic [10:0] f_div_step(input logic [10:0] rem, input logic b,
                                               input logic [10:0] n);
        logic [11:0] t;
        t = {rem, b};
        if (t >= {1'b0, n}) begin
            t = t - {1'b0, n};
        end
        return t[10:0];
    endfunction

    // mod PRIME front end
    logic [3:0]         r_fv;
    logic [42:0]        r_x;
    logic [42:0]        r_x1;
    logic [22:0]        r_q;
    logic [23:0]        r_r;
    logic [20:0]        r_h;
    logic [10:0]        r_n  [4];
    logic [SbWidth-1:0] r_sb [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (i_en) begin
            r_fv <= {r_fv[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x     <= 43'(i_mult) * 43'(i_kr) + 43'(i_add);
            r_n[0]  <= i_modulus;
            r_sb[0] <= i_sb;
            r_q     <= f_quot_est(r_x);
            r_x1    <= r_x;
            r_r     <= f_rem_est(r_x1, r_q);
            r_h     <= f_rem_fix(r_r);
            for (int k = 1; k < 4; k++) begin
                r_n[k]  <= r_n[k-1];
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // restoring remainder, one dividend bit per stage
    logic [DivSteps-1:0] r_dv;
    logic [10:0]         r_drem [DivSteps];
    logic [20:0]         r_dh   [DivSteps];
    logic [10:0]         r_dn   [DivSteps];
    logic [SbWidth-1:0]  r_dsb  [DivSteps];

    logic [10:0]         w_rem_in [DivSteps];
    logic [20:0]         w_h_in   [DivSteps];
    logic [10:0]         w_n_in   [DivSteps];
    logic [SbWidth-1:0]  w_sb_in  [DivSteps];

    always_comb begin
        w_rem_in[0] = '0;
        w_h_in[0]   = r_h;
        w_n_in[0]   = r_n[3];
        w_sb_in[0]  = r_sb[3];
        for (int k = 1; k < DivSteps; k++) begin
            w_rem_in[k] = r_drem[k-1];
            w_h_in[k]   = r_dh[k-1];
            w_n_in[k]   = r_dn[k-1];
            w_sb_in[k]  = r_dsb[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (i_en) begin
            r_dv <= {r_dv[DivSteps-2:0], r_fv[3]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DivSteps; k++) begin
                r_drem[k] <= f_div_step(w_rem_in[k], w_h_in[k][20], w_n_in[k]);
                r_dh[k]   <= {w_h_in[k][19:0], 1'b0};
                r_dn[k]   <= w_n_in[k];
                r_dsb[k]  <= w_sb_in[k];
            end
        end
    end

    assign o_valid = r_dv[DivSteps-1];
    assign o_rem   = r_drem[DivSteps-1];
    assign o_sb    = r_dsb[DivSteps-1];

endmodule

/* design/two_level_perfect_hash_lookup_core.sv */
`timescale 1ns / 1ps
// Channel   Handshake                    Payload
// -------   ---------------------------  -----------------------------------------
// in        i_in_valid / o_in_ready      i_func, i_entry_index, i_key, i_bucket_*,
//                                        i_slot_count, i_slot_base, i_slot_valid
// out       o_out_valid / i_out_ready    o_found, o_was_query
// cfg       i_cfg_we                     i_cfg_index, i_cfg_data
//
// One item per cycle while not held; an item passes the input register, key
// reduction, two mod-PRIME-plus-divider pipelines, both memory stages and the
// result register. After reset the slot store is cleared with o_in_ready low.
// The whole pipeline holds while a result waits in the output register.
module two_level_perfect_hash_lookup_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [20:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic [9:0]         i_entry_index,
    input  logic signed [31:0] i_key,
    input  logic [20:0]        i_bucket_mult,
    input  logic [20:0]        i_bucket_add,
    input  logic [10:0]        i_slot_count,
    input  logic [9:0]         i_slot_base,
    input  logic               i_slot_valid,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_found,
    output logic               o_was_query
);
    import phl_pkg::*;

    localparam int L1W = $bits(t_l1_sb);
    localparam int L2W = $bits(t_l2_sb);

    logic [20:0] r_first_mult;
    logic [20:0] r_first_add;
    logic [8:0]  r_num_buckets;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_mult  <= 21'd1;
            r_first_add   <= '0;
            r_num_buckets <= 9'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIRST_MULT:  r_first_mult  <= i_cfg_data;
                CFG_FIRST_ADD:   r_first_add   <= i_cfg_data;
                CFG_NUM_BUCKETS: r_num_buckets <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    logic               r_clr_busy;
    logic [SLOT_AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == SLOT_AW'(SLOTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    logic  r_out_valid;
    logic  w_en;
    logic  w_accept;
    t_item w_item;

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en && !r_clr_busy;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_item = '{func: i_func, idx: i_entry_index, key: $unsigned(i_key),
                      bmult: i_bucket_mult, badd: i_bucket_add, count: i_slot_count,
                      base: i_slot_base, svalid: i_slot_valid};

    // input register and key reduction mod PRIME
    logic        r_p0_v;
    t_item       r_p0;
    logic [3:0]  r_kv;
    t_item       r_k_item [4];
    logic [42:0] r_k1_x;
    logic [42:0] r_k2_x;
    logic [22:0] r_k2_q;
    logic [23:0] r_k3_r;
    logic [20:0] r_k4_kr;
    logic [42:0] w_kx;

    assign w_kx = 43'({~r_p0.key[31], r_p0.key[30:0]}) + 43'(KEY_OFS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_v <= 1'b0;
            r_kv   <= '0;
        end else if (w_en) begin
            r_p0_v <= w_accept;
            r_kv   <= {r_kv[2:0], r_p0_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0        <= w_item;
            r_k_item[0] <= r_p0;
            r_k1_x      <= w_kx;
            r_k2_q      <= f_quot_est(r_k1_x);
            r_k2_x      <= r_k1_x;
            r_k3_r      <= f_rem_est(r_k2_x, r_k2_q);
            r_k4_kr     <= f_rem_fix(r_k3_r);
            for (int k = 1; k < 4; k++) begin
                r_k_item[k] <= r_k_item[k-1];
            end
        end
    end

    // level one hash
    t_l1_sb           w_l1_in;
    logic             w_h1_v;
    logic [10:0]      w_h1_rem;
    logic [L1W-1:0]   w_h1_sb;
    t_l1_sb           w_l1;

    assign w_l1_in = '{item: r_k_item[3], kr: r_k4_kr};
    assign w_l1    = t_l1_sb'(w_h1_sb);

    phl_hash #(.SbWidth(L1W)) u_hash1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (r_kv[3]),
        .i_mult    (r_first_mult),
        .i_add     (r_first_add),
        .i_modulus ({2'b00, r_num_buckets}),
        .i_kr      (r_k4_kr),
        .i_sb      (L1W'(w_l1_in)),
        .o_valid   (w_h1_v),
        .o_rem     (w_h1_rem),
        .o_sb      (w_h1_sb)
    );

    // bucket descriptor stage
    t_bucket r_bkt_mem [BUCKETS];
    t_bucket r_b_rd;
    t_l1_sb  r_b_sb;
    logic    r_b_v;
    logic    r_b_qok;

    always_ff @(posedge i_clk) begin
        if (w_en && w_h1_v) begin
            if (w_l1.item.func == FUNC_DESC && 32'(w_l1.item.idx) < BUCKETS) begin
                r_bkt_mem[w_l1.item.idx[BKT_AW-1:0]] <= '{mult: w_l1.item.bmult,
                    add: w_l1.item.badd, count: w_l1.item.count, base: w_l1.item.base};
            end else begin
                r_b_rd <= r_bkt_mem[w_h1_rem[BKT_AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_b_v <= w_h1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_sb  <= w_l1;
            r_b_qok <= (r_num_buckets != '0) && (32'(w_h1_rem) < BUCKETS);
        end
    end

    // level two hash
    t_l2_sb         w_l2_in;
    logic           w_h2_v;
    logic [10:0]    w_h2_rem;
    logic [L2W-1:0] w_h2_sb;
    t_l2_sb         w_l2;

    assign w_l2_in = '{func: r_b_sb.item.func, idx: r_b_sb.item.idx, key: r_b_sb.item.key,
                       svalid: r_b_sb.item.svalid, base: r_b_rd.base,
                       ok: r_b_qok && (r_b_rd.count != '0)};
    assign w_l2    = t_l2_sb'(w_h2_sb);

    phl_hash #(.SbWidth(L2W)) u_hash2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (r_b_v),
        .i_mult    (r_b_rd.mult),
        .i_add     (r_b_rd.add),
        .i_modulus (r_b_rd.count),
        .i_kr      (r_b_sb.kr),
        .i_sb      (L2W'(w_l2_in)),
        .o_valid   (w_h2_v),
        .o_rem     (w_h2_rem),
        .o_sb      (w_h2_sb)
    );

    // slot stage
    t_slot       r_slot_mem [SLOTS];
    t_slot       r_s_rd;
    logic        r_s_v;
    logic [1:0]  r_s_func;
    logic [31:0] r_s_key;
    logic        r_s_ok;
    logic [11:0] w_saddr;

    assign w_saddr = 12'(w_l2.base) + 12'(w_h2_rem);

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_slot_mem[r_clr_addr] <= '0;
        end else if (w_en && w_h2_v) begin
            if (w_l2.func == FUNC_SLOT && 32'(w_l2.idx) < SLOTS) begin
                r_slot_mem[w_l2.idx[SLOT_AW-1:0]] <= '{valid: w_l2.svalid, key: w_l2.key};
            end else begin
                r_s_rd <= r_slot_mem[w_saddr[SLOT_AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (w_en) begin
            r_s_v <= w_h2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_func <= w_l2.func;
            r_s_key  <= w_l2.key;
            r_s_ok   <= w_l2.ok && (32'(w_saddr) < SLOTS);
        end
    end

    // result register
    logic r_found;
    logic r_was_query;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_was_query <= (r_s_func == FUNC_QUERY);
            r_found     <= (r_s_func == FUNC_QUERY) && r_s_ok && r_s_rd.valid
                           && (r_s_rd.key == r_s_key);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_was_query = r_was_query;

endmodule
